/* src/grouped_fifo_queue_manager_macros.svh */
// ----------------------------------------------------------------------------
// grouped_fifo_queue_manager_macros
// Assertion shorthands shared by the team queue RTL.
// ----------------------------------------------------------------------------
`ifndef GROUPED_FIFO_QUEUE_MANAGER_MACROS_SVH
`define GROUPED_FIFO_QUEUE_MANAGER_MACROS_SVH

// same-cycle implication, checked outside reset
`define GFQ_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define GFQ_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/gfq_pkg.sv */
// ----------------------------------------------------------------------------
// gfq_pkg
// Shared widths, codes and memory control types of the team queue.
// ----------------------------------------------------------------------------
package gfq_pkg;

  localparam int unsigned GROUPS_DEF  = 1024;
  localparam int unsigned ENTRIES_DEF = 1024;

  localparam int unsigned MEMBER_W = 20;
  localparam int unsigned GROUP_W  = 10;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // write enables: group record, group-order ring slot, pool member, pool link
  typedef struct packed {
    logic grp_rec;
    logic grp_ring;
    logic pool_member;
    logic pool_link;
  } mem_we_t;

  typedef struct packed {
    logic grp_rd;
    logic pool_rd;
  } mem_rd_t;

endpackage

/* src/gfq_if.sv */
// ----------------------------------------------------------------------------
// gfq_if
// Valid/ready channels of the team queue: request and response.
// ----------------------------------------------------------------------------
interface gfq_in_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [gfq_pkg::MEMBER_W-1:0] member_id;
  logic [gfq_pkg::GROUP_W-1:0]  group_id;

  modport source (output valid, req_type, member_id, group_id, input ready);
  modport sink   (input valid, req_type, member_id, group_id, output ready);
endinterface

interface gfq_out_if;
  logic                         valid;
  logic                         ready;
  logic [gfq_pkg::MEMBER_W-1:0] member_out;
  logic [gfq_pkg::GROUP_W-1:0]  group_out;
  logic [gfq_pkg::STATUS_W-1:0] status;

  modport source (output valid, member_out, group_out, status, input ready);
  modport sink   (input valid, member_out, group_out, status, output ready);
endinterface

/* src/gfq_mem.sv */
// ----------------------------------------------------------------------------
// gfq_mem
// Group memory {busy, head, tail, order slot} and member pool {member, link},
// registered synchronous reads, field write enables, busy clearing after reset.
// ----------------------------------------------------------------------------
module gfq_mem #(
  parameter int unsigned GROUPS  = gfq_pkg::GROUPS_DEF,
  parameter int unsigned ENTRIES = gfq_pkg::ENTRIES_DEF,
  localparam int unsigned GAW = (GROUPS > 1) ? $clog2(GROUPS) : 1,
  localparam int unsigned EAW = $clog2(ENTRIES)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  output logic                         clr_busy_o,
  input  gfq_pkg::mem_we_t             we_i,
  input  gfq_pkg::mem_rd_t             rd_i,
  input  logic [GAW-1:0]               grp_raddr_i,
  input  logic [GAW-1:0]               grp_waddr_i,
  input  logic                         grp_wbusy_i,
  input  logic [EAW-1:0]               grp_whead_i,
  input  logic [EAW-1:0]               grp_wtail_i,
  input  logic [GAW-1:0]               grp_wring_i,
  output logic                         grp_rbusy_o,
  output logic [EAW-1:0]               grp_rhead_o,
  output logic [EAW-1:0]               grp_rtail_o,
  output logic [GAW-1:0]               grp_rring_o,
  input  logic [EAW-1:0]               pool_raddr_i,
  input  logic [EAW-1:0]               pool_waddr_i,
  input  logic [gfq_pkg::MEMBER_W-1:0] pool_wmember_i,
  input  logic [EAW-1:0]               pool_wlink_i,
  output logic [gfq_pkg::MEMBER_W-1:0] pool_rmember_o,
  output logic [EAW-1:0]               pool_rlink_o
);

  localparam int unsigned REC_W  = 1 + 2 * EAW;
  localparam int unsigned GWORD_W = REC_W + GAW;
  localparam int unsigned PWORD_W = gfq_pkg::MEMBER_W + EAW;

  logic [GWORD_W-1:0] gmem_q [GROUPS];
  logic [PWORD_W-1:0] pmem_q [ENTRIES];
  logic [GWORD_W-1:0] grdata_q;
  logic [PWORD_W-1:0] prdata_q;

  logic           clr_active_q, clr_active_d;
  logic [GAW-1:0] clr_idx_q, clr_idx_d;

  logic             g_rec_we;
  logic [GAW-1:0]   g_rec_addr;
  logic [REC_W-1:0] g_rec_data;

  // one busy bit cleared per cycle after reset
  always_comb begin
    clr_active_d = clr_active_q;
    clr_idx_d    = clr_idx_q;
    if (clr_active_q) begin
      if (clr_idx_q == GAW'(GROUPS - 1)) begin
        clr_active_d = 1'b0;
      end else begin
        clr_idx_d = clr_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_idx_q    <= '0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_idx_q    <= clr_idx_d;
    end
  end

  assign clr_busy_o = clr_active_q;

  assign g_rec_we   = we_i.grp_rec || clr_active_q;
  assign g_rec_addr = clr_active_q ? clr_idx_q : grp_waddr_i;
  assign g_rec_data = clr_active_q ? '0 : {grp_wbusy_i, grp_whead_i, grp_wtail_i};

  always_ff @(posedge clk_i) begin
    if (g_rec_we) begin
      gmem_q[g_rec_addr][GWORD_W-1:GAW] <= g_rec_data;
    end
    if (we_i.grp_ring) begin
      gmem_q[grp_waddr_i][GAW-1:0] <= grp_wring_i;
    end
    if (rd_i.grp_rd) begin
      grdata_q <= gmem_q[grp_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i.pool_member) begin
      pmem_q[pool_waddr_i][PWORD_W-1:EAW] <= pool_wmember_i;
    end
    if (we_i.pool_link) begin
      pmem_q[pool_waddr_i][EAW-1:0] <= pool_wlink_i;
    end
    if (rd_i.pool_rd) begin
      prdata_q <= pmem_q[pool_raddr_i];
    end
  end

  assign grp_rbusy_o    = grdata_q[GWORD_W-1];
  assign grp_rhead_o    = grdata_q[GAW+2*EAW-1:GAW+EAW];
  assign grp_rtail_o    = grdata_q[GAW+EAW-1:GAW];
  assign grp_rring_o    = grdata_q[GAW-1:0];
  assign pool_rmember_o = prdata_q[PWORD_W-1:EAW];
  assign pool_rlink_o   = prdata_q[EAW-1:0];

endmodule

/* src/grouped_fifo_queue_manager.sv */
// ----------------------------------------------------------------------------
// grouped_fifo_queue_manager
// Team queue: per-group FIFOs in a shared linked-list pool, served in the
// order in which the groups became non-empty.
// ----------------------------------------------------------------------------
//  channel | dir | beat carries
//  req_i   | in  | req_type, member_id, group_id
//  rsp_o   | out | member_out, group_out, status (one beat per request)
//
//  enqueue steps: group and free-link read, node/record write, then link or
//  order-slot write; dequeue steps: order slot, group record and pool node
//  read in chain, then write-back; empty and full go straight to the response.
//  after reset a clearing pass over all GROUPS records resets the busy bits;
//  req_i.ready stays low during it.
//  a new request is taken while the previous response waits in the output
//  register; a request's last cycle holds until that register is free.
// ----------------------------------------------------------------------------
`include "grouped_fifo_queue_manager_macros.svh"

module grouped_fifo_queue_manager #(
  parameter int unsigned GROUPS  = gfq_pkg::GROUPS_DEF,
  parameter int unsigned ENTRIES = gfq_pkg::ENTRIES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gfq_in_if.sink    req_i,
  gfq_out_if.source rsp_o
);

  localparam int unsigned GAW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int unsigned EAW = $clog2(ENTRIES);
  localparam int unsigned OCW = $clog2(GROUPS + 1);
  localparam int unsigned UCW = $clog2(ENTRIES + 1);
  localparam int unsigned MW  = gfq_pkg::MEMBER_W;
  localparam int unsigned GW  = gfq_pkg::GROUP_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ENQ1 = 3'd1;
  localparam logic [2:0] S_ENQ2 = 3'd2;
  localparam logic [2:0] S_DEQ1 = 3'd3;
  localparam logic [2:0] S_DEQ2 = 3'd4;
  localparam logic [2:0] S_DEQ3 = 3'd5;
  localparam logic [2:0] S_RESP = 3'd6;

  logic [2:0] state_q, state_d;

  // queue bookkeeping
  logic [GAW-1:0] ohead_q, ohead_d, otail_q, otail_d;
  logic [OCW-1:0] ocnt_q, ocnt_d;
  logic [EAW-1:0] free_head_q, free_head_d;
  logic [UCW-1:0] fresh_q, fresh_d, used_q, used_d;

  // per-request working registers
  logic [MW-1:0]    member_q, member_d;
  logic [GAW-1:0]   grp_q, grp_d, g_q, g_d;
  logic             recycle_q, recycle_d, busy_q, busy_d;
  logic [EAW-1:0]   node_q, node_d, old_tail_q, old_tail_d;
  gfq_pkg::status_e status_q, status_d;

  // response register
  logic             out_valid_q, out_valid_d;
  logic [MW-1:0]    out_member_q;
  logic [GW-1:0]    out_group_q;
  gfq_pkg::status_e out_status_q;

  logic             fin;
  logic [MW-1:0]    fin_member;
  logic [GW-1:0]    fin_group;
  gfq_pkg::status_e fin_status;

  // memory side
  gfq_pkg::mem_we_t we;
  gfq_pkg::mem_rd_t rd;
  logic             clr_busy;
  logic [GAW-1:0]   grp_raddr, grp_waddr, grp_wring, grp_rring;
  logic             grp_wbusy, grp_rbusy;
  logic [EAW-1:0]   grp_whead, grp_wtail, grp_rhead, grp_rtail;
  logic [EAW-1:0]   pool_raddr, pool_waddr, pool_wlink, pool_rlink;
  logic [MW-1:0]    pool_rmember;

  logic in_acc, out_free, recycle, enq_full, last_node;
  logic [EAW-1:0] new_node;

  gfq_mem #(
    .GROUPS  (GROUPS),
    .ENTRIES (ENTRIES)
  ) u_mem (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .clr_busy_o     (clr_busy),
    .we_i           (we),
    .rd_i           (rd),
    .grp_raddr_i    (grp_raddr),
    .grp_waddr_i    (grp_waddr),
    .grp_wbusy_i    (grp_wbusy),
    .grp_whead_i    (grp_whead),
    .grp_wtail_i    (grp_wtail),
    .grp_wring_i    (grp_wring),
    .grp_rbusy_o    (grp_rbusy),
    .grp_rhead_o    (grp_rhead),
    .grp_rtail_o    (grp_rtail),
    .grp_rring_o    (grp_rring),
    .pool_raddr_i   (pool_raddr),
    .pool_waddr_i   (pool_waddr),
    .pool_wmember_i (member_q),
    .pool_wlink_i   (pool_wlink),
    .pool_rmember_o (pool_rmember),
    .pool_rlink_o   (pool_rlink)
  );

  assign req_i.ready = (state_q == S_IDLE) && !clr_busy;
  assign in_acc      = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign recycle   = fresh_q > used_q;
  assign enq_full  = (32'(used_q) >= ENTRIES) || (32'(req_i.group_id) >= GROUPS) ||
                     (!recycle && (32'(fresh_q) >= ENTRIES));
  assign new_node  = recycle_q ? free_head_q : EAW'(fresh_q);
  assign last_node = grp_rhead == grp_rtail;

  always_comb begin
    state_d     = state_q;
    ohead_d     = ohead_q;
    otail_d     = otail_q;
    ocnt_d      = ocnt_q;
    free_head_d = free_head_q;
    fresh_d     = fresh_q;
    used_d      = used_q;
    member_d    = member_q;
    grp_d       = grp_q;
    g_d         = g_q;
    recycle_d   = recycle_q;
    busy_d      = busy_q;
    node_d      = node_q;
    old_tail_d  = old_tail_q;
    status_d    = status_q;

    we         = '0;
    rd         = '0;
    grp_raddr  = ohead_q;
    grp_waddr  = grp_q;
    grp_wbusy  = 1'b1;
    grp_whead  = new_node;
    grp_wtail  = new_node;
    grp_wring  = grp_q;
    pool_raddr = free_head_q;
    pool_waddr = new_node;
    pool_wlink = '0;

    fin        = 1'b0;
    fin_member = '0;
    fin_group  = '0;
    fin_status = gfq_pkg::ST_ENQ;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (req_i.req_type == gfq_pkg::REQ_DEQ) begin
            if (ocnt_q == '0) begin
              status_d = gfq_pkg::ST_EMPTY;
              state_d  = S_RESP;
            end else begin
              rd.grp_rd = 1'b1;
              grp_raddr = ohead_q;
              state_d   = S_DEQ1;
            end
          end else if (enq_full) begin
            status_d = gfq_pkg::ST_FULL;
            state_d  = S_RESP;
          end else begin
            // group record and the free list's next link in parallel
            rd.grp_rd  = 1'b1;
            rd.pool_rd = 1'b1;
            grp_raddr  = GAW'(req_i.group_id);
            pool_raddr = free_head_q;
            member_d   = req_i.member_id;
            grp_d      = GAW'(req_i.group_id);
            recycle_d  = recycle;
            state_d    = S_ENQ1;
          end
        end
      end
      S_ENQ1: begin
        we.pool_member = 1'b1;
        we.pool_link   = 1'b1;
        pool_waddr     = new_node;
        pool_wlink     = '0;
        we.grp_rec     = 1'b1;
        grp_waddr      = grp_q;
        grp_wbusy      = 1'b1;
        grp_whead      = grp_rbusy ? grp_rhead : new_node;
        grp_wtail      = new_node;
        node_d         = new_node;
        busy_d         = grp_rbusy;
        old_tail_d     = grp_rtail;
        if (recycle_q) begin
          free_head_d = pool_rlink;
        end else begin
          fresh_d = fresh_q + 1'b1;
        end
        used_d  = used_q + 1'b1;
        state_d = S_ENQ2;
      end
      S_ENQ2: begin
        if (out_free) begin
          if (!busy_q) begin
            // group was idle: it joins the tail of the order ring
            if (32'(ocnt_q) < GROUPS) begin
              we.grp_ring = 1'b1;
              grp_waddr   = otail_q;
              grp_wring   = grp_q;
              otail_d     = (otail_q == GAW'(GROUPS - 1)) ? '0 : otail_q + 1'b1;
              ocnt_d      = ocnt_q + 1'b1;
            end
          end else begin
            we.pool_link = 1'b1;
            pool_waddr   = old_tail_q;
            pool_wlink   = node_q;
          end
          fin        = 1'b1;
          fin_status = gfq_pkg::ST_ENQ;
          state_d    = S_IDLE;
        end
      end
      S_DEQ1: begin
        rd.grp_rd = 1'b1;
        grp_raddr = grp_rring;
        g_d       = grp_rring;
        state_d   = S_DEQ2;
      end
      S_DEQ2: begin
        rd.pool_rd = 1'b1;
        pool_raddr = grp_rhead;
        state_d    = S_DEQ3;
      end
      S_DEQ3: begin
        if (out_free) begin
          we.grp_rec = 1'b1;
          grp_waddr  = g_q;
          grp_wbusy  = !last_node;
          grp_whead  = last_node ? grp_rhead : pool_rlink;
          grp_wtail  = grp_rtail;
          if (last_node) begin
            ohead_d = (ohead_q == GAW'(GROUPS - 1)) ? '0 : ohead_q + 1'b1;
            ocnt_d  = ocnt_q - 1'b1;
          end
          // node goes back onto the free list
          we.pool_link = 1'b1;
          pool_waddr   = grp_rhead;
          pool_wlink   = free_head_q;
          free_head_d  = grp_rhead;
          if (used_q != '0) begin
            used_d = used_q - 1'b1;
          end
          fin        = 1'b1;
          fin_member = pool_rmember;
          fin_group  = GW'(g_q);
          fin_status = gfq_pkg::ST_DEQ;
          state_d    = S_IDLE;
        end
      end
      S_RESP: begin
        if (out_free) begin
          fin        = 1'b1;
          fin_status = status_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = fin ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ohead_q     <= '0;
      otail_q     <= '0;
      ocnt_q      <= '0;
      free_head_q <= '0;
      fresh_q     <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ohead_q     <= ohead_d;
      otail_q     <= otail_d;
      ocnt_q      <= ocnt_d;
      free_head_q <= free_head_d;
      fresh_q     <= fresh_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    member_q   <= member_d;
    grp_q      <= grp_d;
    g_q        <= g_d;
    recycle_q  <= recycle_d;
    busy_q     <= busy_d;
    node_q     <= node_d;
    old_tail_q <= old_tail_d;
    status_q   <= status_d;
    if (fin) begin
      out_member_q <= fin_member;
      out_group_q  <= fin_group;
      out_status_q <= fin_status;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.member_out = out_member_q;
  assign rsp_o.group_out  = out_group_q;
  assign rsp_o.status     = out_status_q;

  `GFQ_ASSERT_IMP(a_fresh_covers_used, clk_i, rst_ni, 1'b1,
    (fresh_q >= used_q) && (32'(fresh_q) <= ENTRIES), "pool counters out of order")
  `GFQ_ASSERT_IMP(a_order_le_used, clk_i, rst_ni, 1'b1,
    (32'(ocnt_q) <= 32'(used_q)) && (32'(ocnt_q) <= GROUPS), "group order exceeds members")
  `GFQ_ASSERT_NXT(a_last_member_leaves, clk_i, rst_ni,
    (state_q == S_DEQ3) && out_free && last_node,
    ocnt_q == OCW'($past(ocnt_q) - 1'b1), "emptied group did not leave the order")
  `GFQ_ASSERT_IMP(a_no_write_in_clear, clk_i, rst_ni, clr_busy,
    !(we.grp_rec || we.grp_ring || we.pool_member || we.pool_link),
    "memory write during busy clearing")
  `GFQ_ASSERT_IMP(a_zero_payload, clk_i, rst_ni,
    rsp_o.valid && (out_status_q != gfq_pkg::ST_DEQ),
    (out_member_q == '0) && (out_group_q == '0), "non-dequeue beat carries data")

endmodule
